>>> sv/bracket_color_frame_parser_defines.svh
// Assertion macros for the bracket colour frame parser checker.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef BRACKET_COLOR_FRAME_PARSER_DEFINES_SVH
`define BRACKET_COLOR_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication.
`define BCFP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bcfp assertion failed");

// Next-cycle implication.
`define BCFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bcfp assertion failed");

`endif

>>> sv/bcfp_pkg.sv
// Package for the bracket colour frame parser: command and register codes,
// reset values and the result type. No dependencies.
package bcfp_pkg;

  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_UP   = 2'd1,
    CMD_DOWN = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_START = 2'd0,
    CFG_END   = 2'd1,
    CFG_LIMIT = 2'd2
  } cfg_idx_e;

  localparam logic [7:0] StartMarkerReset = 8'h5B;
  localparam logic [7:0] EndMarkerReset   = 8'h5D;
  localparam logic [7:0] ModeLimitReset   = 8'd11;

  typedef struct packed {
    logic [7:0] mode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_applied;
  } result_t;

endpackage

>>> sv/bracket_color_frame_parser.sv
// Bracket colour frame parser: frame capture, mode buttons, output skid.
// Depends on bcfp_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries a command: a received
//   byte, an up-button event or a down-button event. A transfer happens at
//   a rising edge with valid high and stall low.
//   Output channel (out_valid_o / out_stall_i) returns one result per input
//   transfer: current mode, red, green, blue and a frame-applied flag.
//   Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_wdata_i)
//   for start marker, end marker and mode limit; other indexes are ignored.
//   Results are registered: in the output register, or in the skid register.
//   Throughput: one item per cycle while in_stall_o is low; all state updates
//   in the cycle of the transfer, so no item waits on the one before it.
//   Stall: an output register and a one-entry skid register part the sides;
//   in_stall_o rises only once both hold results: it is the skid's valid flag,
//   set when a transfer arrives while the receiver stalls a held result.
//   Reset: markers return to 0x5B and 0x5D, limit to 11; frame state, store,
//   mode and colours clear to zero; both result registers empty.
module bracket_color_frame_parser
  import bcfp_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] command_i,
  input  logic [7:0] rx_byte_i,
  input  logic       up_pin_high_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] mode_o,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o,
  output logic       frame_applied_o
);

  localparam int unsigned CntW = $clog2(FRAME_BYTES + 1);
  localparam int unsigned IdxW = $clog2(FRAME_BYTES);

  logic [7:0]      start_q, end_q, limit_q;
  logic            in_frame_q, in_frame_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [7:0]      store_q [FRAME_BYTES];
  logic [7:0]      store_d [FRAME_BYTES];
  logic [7:0]      mode_q, mode_d;
  logic [7:0]      color_q [3];
  logic [7:0]      color_d [3];
  logic            applied;
  logic            in_xfer;
  logic            out_free;
  result_t         res_new, out_q, skid_q;
  logic            out_valid_q, skid_valid_q;

  assign in_xfer  = in_valid_i && !skid_valid_q;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= StartMarkerReset;
      end_q   <= EndMarkerReset;
      limit_q <= ModeLimitReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_START: start_q <= cfg_wdata_i;
        CFG_END:   end_q   <= cfg_wdata_i;
        CFG_LIMIT: limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_frame_d = in_frame_q;
    fill_d     = fill_q;
    store_d    = store_q;
    mode_d     = mode_q;
    color_d    = color_q;
    applied    = 1'b0;
    if (in_xfer) begin
      case (command_i)
        CMD_BYTE: begin
          if (rx_byte_i == start_q || in_frame_q) begin
            if (fill_q >= CntW'(FRAME_BYTES)) begin
              in_frame_d = 1'b0;
              fill_d     = '0;
            end else begin
              store_d[fill_q[IdxW-1:0]] = rx_byte_i;
              fill_d     = fill_q + CntW'(1);
              in_frame_d = 1'b1;
            end
          end
          if (rx_byte_i == end_q && in_frame_d) begin
            mode_d     = store_d[1];
            color_d[0] = store_d[2];
            color_d[1] = store_d[3];
            color_d[2] = store_d[4];
            in_frame_d = 1'b0;
            fill_d     = '0;
            applied    = 1'b1;
          end
        end
        CMD_UP: begin
          if (up_pin_high_i && mode_q < limit_q) begin
            mode_d = mode_q + 8'd1;
          end
        end
        CMD_DOWN: begin
          if (mode_q != 8'd0) begin
            mode_d = mode_q - 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign res_new = '{mode:          mode_d,
                     red:           color_d[0],
                     green:         color_d[1],
                     blue:          color_d[2],
                     frame_applied: applied};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      fill_q     <= '0;
      mode_q     <= '0;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        store_q[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        color_q[i] <= '0;
      end
    end else begin
      in_frame_q <= in_frame_d;
      fill_q     <= fill_d;
      mode_q     <= mode_d;
      store_q    <= store_d;
      color_q    <= color_d;
    end
  end

  // when the output frees up, load it from skid or else the new result; else park new result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || in_xfer;
      skid_valid_q <= 1'b0;
    end else if (in_xfer) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res_new;
    end else if (in_xfer) begin
      skid_q <= res_new;
    end
  end

  assign in_stall_o      = skid_valid_q;
  assign out_valid_o     = out_valid_q;
  assign mode_o          = out_q.mode;
  assign red_o           = out_q.red;
  assign green_o         = out_q.green;
  assign blue_o          = out_q.blue;
  assign frame_applied_o = out_q.frame_applied;

endmodule

>>> sv/bcfp_checker.sv
// Port-level checker for the bracket colour frame parser, bound to the top.
// Depends on bracket_color_frame_parser_defines.svh.
`include "bracket_color_frame_parser_defines.svh"

module bcfp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] mode_o,
  input logic [7:0] red_o,
  input logic [7:0] green_o,
  input logic [7:0] blue_o,
  input logic       frame_applied_o
);

  `BCFP_ASSERT_NEXT(a_out_hold_valid, out_valid_o && out_stall_i, out_valid_o)
  `BCFP_ASSERT_NEXT(a_out_hold_data, out_valid_o && out_stall_i,
                    $stable({mode_o, red_o, green_o, blue_o, frame_applied_o}))
  `BCFP_ASSERT_NOW(a_stall_needs_result, in_stall_o, out_valid_o)
  `BCFP_ASSERT_NEXT(a_transfer_shows, in_valid_i && !in_stall_o && !out_valid_o, out_valid_o)

endmodule

bind bracket_color_frame_parser bcfp_checker u_bcfp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .mode_o          (mode_o),
  .red_o           (red_o),
  .green_o         (green_o),
  .blue_o          (blue_o),
  .frame_applied_o (frame_applied_o)
);
